// File: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, codes and helpers of the block bitmap allocator: operation
// codes, controller states and the byte search for the lowest free block.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // operation codes of an input item
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_SET   = 2'd1,
    OP_LOAD  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  // controller states, one-hot
  typedef enum logic [4:0] {
    ST_WIPE   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_MODIFY = 5'b01000,
    ST_SCAN   = 5'b10000
  } state_e;

  // width of a bitmap byte and of a bit position inside it
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W  = 3;

  // search result over one byte: lowest block is the msb
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } hit_t;

  // lowest free bit of a byte, counted from the msb
  function automatic hit_t first_free_bit(input logic [BYTE_W-1:0] free);
    hit_t h;
    h.found = 1'b0;
    h.pos   = '0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (free[k]) begin
        h.found = 1'b1;
        h.pos   = POS_W'(BYTE_W - 1 - k);
      end
    end
    return h;
  endfunction

endpackage

`default_nettype wire

// File: src/bba_mem.sv
// ----------------------------------------------------------------------------
// bba_mem
// Occupancy byte store: one write port and two read ports, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [AW-1:0]              waddr_i,
  input  wire logic [bba_pkg::BYTE_W-1:0] wdata_i,
  input  wire logic [AW-1:0]              raddr_a_i,
  output logic      [bba_pkg::BYTE_W-1:0] rdata_a_o,
  input  wire logic [AW-1:0]              raddr_b_i,
  output logic      [bba_pkg::BYTE_W-1:0] rdata_b_o
);

  logic [bba_pkg::BYTE_W-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read ports
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// File: src/block_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// block_bitmap_allocator_unit
// First-fit free block bitmap: one occupancy bit per block in a byte memory,
// plus a pointer to the lowest free block kept up to date on every item.
// ----------------------------------------------------------------------------
//
//  channel   ports                                              timing
//  -------   ------------------------------------------------   ---------------
//  command   start_i busy_o op_i block_address_i byte_index_i   taken: start&!busy
//            byte_data_i
//  result    done_o block_was_used_o first_free_o no_space_o    one-cycle strobe
//            read_data_o
//
//  Clear, read and a set that needs no rescan pass through fetch and modify;
//  a new item can be taken during modify, so such items follow back to back.
//  The result strobe is registered and rises in the cycle after modify or scan ends.
//  A load in range, or a set at or below the free pointer, rescans the bitmap
//  one byte per cycle through the second read port. After reset a clearing
//  pass writes zero to every byte, with busy_o high. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator_unit #(
  parameter int unsigned BLOCK_COUNT = 65536
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [15:0] block_address_i,
  input  wire logic [12:0] byte_index_i,
  input  wire logic [7:0]  byte_data_i,
  output logic             done_o,
  output logic             block_was_used_o,
  output logic [15:0]      first_free_o,
  output logic             no_space_o,
  output logic [7:0]       read_data_o
);

  localparam int unsigned MAP_BYTES = (BLOCK_COUNT + 7) / 8;
  localparam int unsigned AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int unsigned SAW       = $clog2(MAP_BYTES + 1);
  localparam int unsigned PW        = $clog2(BLOCK_COUNT + 1);
  localparam int unsigned TAIL      = BLOCK_COUNT - 8 * (MAP_BYTES - 1);
  localparam logic [7:0]  TAIL_MASK = 8'(16'hFF00 >> TAIL);
  localparam logic [PW-1:0]  PTR_NONE = PW'(BLOCK_COUNT);
  localparam logic [SAW-1:0] SCAN_END = SAW'(MAP_BYTES);
  localparam logic [AW-1:0]  LAST_BYTE = AW'(MAP_BYTES - 1);

  // state
  bba_pkg::state_e state_q, state_d;
  bba_pkg::op_e    op_q;
  logic [15:0]     blk_q;
  logic [12:0]     idx_q;
  logic [7:0]      data_q;
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [SAW-1:0]  scan_addr_q, scan_addr_d;
  logic            chk_vld_q, chk_vld_d;
  logic [AW-1:0]   chk_addr_q, chk_addr_d;
  logic [AW-1:0]   clr_addr_q, clr_addr_d;
  logic            done_q, done_d;
  logic            was_q, was_d;
  logic [15:0]     ff_q, ff_d;
  logic            ns_q, ns_d;
  logic [7:0]      rd_q, rd_d;

  // memory ports
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;
  logic [AW-1:0]   raddr_a, raddr_b;
  logic [7:0]      rdata_a, rdata_b;

  // item decode
  logic            accept;
  logic            blk_ok, idx_ok;
  logic [PW-1:0]   blk_p;
  logic [7:0]      bit_mask;
  logic            need_scan;
  logic [7:0]      free_bits;
  bba_pkg::hit_t   hit;

  bba_mem #(
    .DEPTH (MAP_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // item decode from the latched command
  assign blk_ok   = {1'b0, blk_q} < 17'(BLOCK_COUNT);
  assign idx_ok   = {1'b0, idx_q} < 14'(MAP_BYTES);
  assign blk_p    = PW'(blk_q);
  assign bit_mask = 8'h80 >> blk_q[2:0];
  assign need_scan = ((op_q == bba_pkg::OP_SET) && blk_ok && (ptr_q >= blk_p)) ||
                     ((op_q == bba_pkg::OP_LOAD) && idx_ok);

  // read addresses: block byte on port a, byte index or scan on port b
  assign raddr_a = AW'(blk_q[15:3]);
  assign raddr_b = (state_q == bba_pkg::ST_SCAN) ? AW'(scan_addr_q) : AW'(idx_q);

  // free bits of the byte under check, tail bits never count
  assign free_bits = ~rdata_b & ((chk_addr_q == LAST_BYTE) ? TAIL_MASK : 8'hFF);
  assign hit       = bba_pkg::first_free_bit(free_bits);

  // handshake
  assign busy_o = !((state_q == bba_pkg::ST_IDLE) ||
                    ((state_q == bba_pkg::ST_MODIFY) && !need_scan));
  assign accept = start_i && !busy_o;

  // controller
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    scan_addr_d = scan_addr_q;
    chk_vld_d   = chk_vld_q;
    chk_addr_d  = chk_addr_q;
    clr_addr_d  = clr_addr_q;
    done_d      = 1'b0;
    was_d       = was_q;
    rd_d        = rd_q;
    ff_d        = ff_q;
    ns_d        = ns_q;
    mem_we      = 1'b0;
    mem_waddr   = AW'(blk_q[15:3]);
    mem_wdata   = rdata_a;

    case (state_q)
      bba_pkg::ST_WIPE: begin
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == LAST_BYTE) begin
          state_d = bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = bba_pkg::ST_FETCH;
        end
      end
      bba_pkg::ST_FETCH: begin
        state_d = bba_pkg::ST_MODIFY;
      end
      bba_pkg::ST_MODIFY: begin
        was_d = blk_ok && ((rdata_a & bit_mask) != 8'h00);
        rd_d  = 8'h00;
        case (op_q)
          bba_pkg::OP_CLEAR: begin
            mem_we    = blk_ok;
            mem_wdata = rdata_a & ~bit_mask;
            if (blk_ok && (ptr_q > blk_p)) begin
              ptr_d = blk_p;
            end
          end
          bba_pkg::OP_SET: begin
            mem_we    = blk_ok;
            mem_wdata = rdata_a | bit_mask;
          end
          bba_pkg::OP_LOAD: begin
            mem_we    = idx_ok;
            mem_waddr = AW'(idx_q);
            mem_wdata = data_q;
          end
          bba_pkg::OP_READ: begin
            rd_d = idx_ok ? rdata_b : 8'h00;
          end
          default: begin
            rd_d = 8'h00;
          end
        endcase
        if (need_scan) begin
          // rescan from the block byte for a set, from zero for a load
          state_d     = bba_pkg::ST_SCAN;
          chk_vld_d   = 1'b0;
          scan_addr_d = (op_q == bba_pkg::OP_SET) ? SAW'(blk_q[15:3]) : '0;
        end else begin
          done_d  = 1'b1;
          state_d = accept ? bba_pkg::ST_FETCH : bba_pkg::ST_IDLE;
        end
      end
      bba_pkg::ST_SCAN: begin
        if (chk_vld_q && hit.found) begin
          ptr_d   = PW'({chk_addr_q, hit.pos});
          done_d  = 1'b1;
          state_d = bba_pkg::ST_IDLE;
        end else if (scan_addr_q < SCAN_END) begin
          chk_vld_d   = 1'b1;
          chk_addr_d  = AW'(scan_addr_q);
          scan_addr_d = scan_addr_q + 1'b1;
        end else begin
          ptr_d   = PTR_NONE;
          done_d  = 1'b1;
          state_d = bba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bba_pkg::ST_IDLE;
      end
    endcase

    // pointer view of the result
    if (done_d) begin
      ns_d = ptr_d >= PTR_NONE;
      ff_d = ns_d ? 16'h0000 : 16'(ptr_d);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bba_pkg::ST_WIPE;
      ptr_q      <= '0;
      clr_addr_q <= '0;
      chk_vld_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      clr_addr_q <= clr_addr_d;
      chk_vld_q  <= chk_vld_d;
      done_q     <= done_d;
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= bba_pkg::op_e'(op_i);
      blk_q  <= block_address_i;
      idx_q  <= byte_index_i;
      data_q <= byte_data_i;
    end
    scan_addr_q <= scan_addr_d;
    chk_addr_q  <= chk_addr_d;
    was_q       <= was_d;
    rd_q        <= rd_d;
    ff_q        <= ff_d;
    ns_q        <= ns_d;
  end

  assign done_o           = done_q;
  assign block_was_used_o = was_q;
  assign first_free_o     = ff_q;
  assign no_space_o       = ns_q;
  assign read_data_o      = rd_q;

  // checks
  a_no_result_in_wipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::ST_WIPE) |-> !done_o)
    else $error("result strobe during clearing pass");

  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bba_pkg::ST_SCAN) |-> !mem_we)
    else $error("memory write during scan");

  a_accept_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ((state_q == bba_pkg::ST_IDLE) || (state_q == bba_pkg::ST_MODIFY)))
    else $error("item taken outside idle or modify");

  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past((state_q == bba_pkg::ST_MODIFY) || (state_q == bba_pkg::ST_SCAN)))
    else $error("result strobe without modify or scan");

endmodule

`default_nettype wire
